### hdl/deflate_lz77_symbol_expander_unit_assert.svh
`ifndef DEFLATE_LZ77_SYMBOL_EXPANDER_UNIT_ASSERT_SVH
`define DEFLATE_LZ77_SYMBOL_EXPANDER_UNIT_ASSERT_SVH
// Assertion helpers, clocked on clk_i and disabled during reset.
`define DLZ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DLZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hdl/dlz_pkg.sv
package dlz_pkg;
  localparam int unsigned SymW = 9;
  localparam int unsigned CfgW = 17;
  localparam int unsigned LenW = 9;
  localparam int unsigned DistW = 16;

  typedef enum logic [2:0] {
    StOk = 3'd0,
    StEnd = 3'd1,
    StBadSym = 3'd2,
    StOverflow = 3'd3,
    StBadDist = 3'd4,
    StFar = 3'd5
  } status_e;

  localparam logic [SymW-1:0] SymEnd = 9'd256;
  localparam logic [SymW-1:0] SymMax = 9'd285;

  typedef struct packed {
    logic [8:0] sym;
    logic [4:0] length_extra;
    logic [4:0] dist_code;
    logic [12:0] dist_extra;
  } in_t;

  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [3:0] count;
    logic last;
    logic [2:0] status;
  } out_t;

  function automatic logic [LenW-1:0] len_decode(input logic [4:0] k, input logic [4:0] ext);
    logic [LenW-1:0] base;
    logic [2:0] nb;
    begin
      nb = 3'd0;
      case (k)
        5'd0: base = 9'd3;    5'd1: base = 9'd4;    5'd2: base = 9'd5;
        5'd3: base = 9'd6;    5'd4: base = 9'd7;    5'd5: base = 9'd8;
        5'd6: base = 9'd9;    5'd7: base = 9'd10;
        5'd8: begin base = 9'd11; nb = 3'd1; end
        5'd9: begin base = 9'd13; nb = 3'd1; end
        5'd10: begin base = 9'd15; nb = 3'd1; end
        5'd11: begin base = 9'd17; nb = 3'd1; end
        5'd12: begin base = 9'd19; nb = 3'd2; end
        5'd13: begin base = 9'd23; nb = 3'd2; end
        5'd14: begin base = 9'd27; nb = 3'd2; end
        5'd15: begin base = 9'd31; nb = 3'd2; end
        5'd16: begin base = 9'd35; nb = 3'd3; end
        5'd17: begin base = 9'd43; nb = 3'd3; end
        5'd18: begin base = 9'd51; nb = 3'd3; end
        5'd19: begin base = 9'd59; nb = 3'd3; end
        5'd20: begin base = 9'd67; nb = 3'd4; end
        5'd21: begin base = 9'd83; nb = 3'd4; end
        5'd22: begin base = 9'd99; nb = 3'd4; end
        5'd23: begin base = 9'd115; nb = 3'd4; end
        5'd24: begin base = 9'd131; nb = 3'd5; end
        5'd25: begin base = 9'd163; nb = 3'd5; end
        5'd26: begin base = 9'd195; nb = 3'd5; end
        5'd27: begin base = 9'd227; nb = 3'd5; end
        default: base = 9'd258;
      endcase
      len_decode = base + LenW'(ext & ((5'd1 << nb) - 5'd1));
    end
  endfunction

  function automatic logic [DistW-1:0] dist_decode(input logic [4:0] d, input logic [12:0] ext);
    logic [DistW-1:0] base;
    logic [3:0] nb;
    begin
      nb = (d < 5'd4) ? 4'd0 : 4'(d[4:1] - 4'd1);
      case (d)
        5'd0: base = 16'd1;     5'd1: base = 16'd2;     5'd2: base = 16'd3;
        5'd3: base = 16'd4;     5'd4: base = 16'd5;     5'd5: base = 16'd7;
        5'd6: base = 16'd9;     5'd7: base = 16'd13;    5'd8: base = 16'd17;
        5'd9: base = 16'd25;    5'd10: base = 16'd33;   5'd11: base = 16'd49;
        5'd12: base = 16'd65;   5'd13: base = 16'd97;   5'd14: base = 16'd129;
        5'd15: base = 16'd193;  5'd16: base = 16'd257;  5'd17: base = 16'd385;
        5'd18: base = 16'd513;  5'd19: base = 16'd769;  5'd20: base = 16'd1025;
        5'd21: base = 16'd1537; 5'd22: base = 16'd2049; 5'd23: base = 16'd3073;
        5'd24: base = 16'd4097; 5'd25: base = 16'd6145; 5'd26: base = 16'd8193;
        5'd27: base = 16'd12289; 5'd28: base = 16'd16385;
        default: base = 16'd24577;
      endcase
      dist_decode = base + DistW'(ext & ((13'd1 << nb) - 13'd1));
    end
  endfunction
endpackage

### hdl/dlz_stream_if.sv
interface dlz_stream_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/deflate_lz77_symbol_expander_unit.sv
// A literal, end of block or error is decoded in SDec and its result is offered in SEmit.
// A match is decoded in SDec, then each byte takes an SRead store read and an SWrite store write,
// with an SEmit after each result of up to LANES (at most 8) bytes (separate read and write
// ports); SEmit holds until out_o.ready, and in_i.ready is high only in SIdle.
// One item at a time: a new item is taken only after the last result of the previous one transfers.
// Reset: write position, sticky error and out_size (to 65536) clear; store is not cleared.
module deflate_lz77_symbol_expander_unit
  import dlz_pkg::*;
#(
  parameter int unsigned OUT_DEPTH = 65536,
  parameter int unsigned LANES = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  dlz_stream_if.sink in_i,
  dlz_stream_if.source out_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  `include "deflate_lz77_symbol_expander_unit_assert.svh"

  localparam int unsigned AddrW = $clog2(OUT_DEPTH);
  localparam int unsigned PosW = AddrW + 1;
  localparam int unsigned NLanes = (LANES > 8) ? 8 : ((LANES < 1) ? 1 : LANES);
  localparam int unsigned LaneW = (NLanes > 1) ? $clog2(NLanes) : 1;
  localparam int unsigned CapW = (CfgW > PosW) ? CfgW : PosW;
  localparam int unsigned CmpW = (DistW > PosW) ? DistW : PosW;
  localparam logic [PosW-1:0] DepthP = PosW'(OUT_DEPTH);

  typedef enum logic [4:0] {
    SIdle = 5'b00001,
    SDec = 5'b00010,
    SRead = 5'b00100,
    SWrite = 5'b01000,
    SEmit = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CfgW-1:0] out_size_q;
  logic [PosW-1:0] write_pos_q, write_pos_d;
  logic error_seen_q, error_seen_d;
  in_t item_q;
  logic [LenW-1:0] remain_q, remain_d;
  logic [DistW-1:0] dist_q, dist_d;
  logic [LaneW:0] fill_q, fill_d;
  out_t res_q, res_d;
  logic match_q, match_d;

  logic [7:0] mem [OUT_DEPTH];
  logic [7:0] rdata_q;
  logic mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata;

  assign pready = 1'b1;
  assign prdata = 32'(out_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_size_q <= CfgW'(65536);
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      out_size_q <= pwdata[CfgW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  logic [PosW-1:0] cap;
  logic [LenW-1:0] len_w;
  logic [DistW-1:0] dist_w;
  assign cap = (CapW'(out_size_q) > CapW'(DepthP)) ? DepthP : PosW'(out_size_q);
  assign len_w = len_decode(5'(item_q.sym - SymW'(257)), item_q.length_extra);
  assign dist_w = dist_decode(item_q.dist_code, item_q.dist_extra);
  assign mem_raddr = AddrW'(write_pos_q - PosW'(dist_q));
  assign mem_waddr = write_pos_q[AddrW-1:0];

  assign in_i.ready = (state_q == SIdle);
  assign out_o.valid = (state_q == SEmit);
  assign out_o.data = res_q;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) item_q <= in_i.data;
  end

  always_comb begin
    state_d = state_q;
    write_pos_d = write_pos_q;
    error_seen_d = error_seen_q;
    remain_d = remain_q;
    dist_d = dist_q;
    fill_d = fill_q;
    res_d = res_q;
    match_d = match_q;
    mem_we = 1'b0;
    mem_wdata = rdata_q;
    case (state_q)
      SIdle: begin
        if (in_i.valid) state_d = SDec;
      end
      SDec: begin
        res_d = '0;
        res_d.last = 1'b1;
        match_d = 1'b0;
        state_d = SEmit;
        if (error_seen_q) begin
          res_d.status = StBadSym;
        end else if (item_q.sym < SymEnd) begin
          if (write_pos_q >= cap) begin
            res_d.status = StOverflow;
            error_seen_d = 1'b1;
          end else begin
            mem_we = 1'b1;
            mem_wdata = item_q.sym[7:0];
            write_pos_d = write_pos_q + PosW'(1);
            res_d.bytes[0] = item_q.sym[7:0];
            res_d.count = 4'd1;
            res_d.status = StOk;
          end
        end else if (item_q.sym == SymEnd) begin
          res_d.status = StEnd;
        end else if (item_q.sym > SymMax) begin
          res_d.status = StBadSym;
          error_seen_d = 1'b1;
        end else if ((PosW+1)'(write_pos_q) + (PosW+1)'(len_w) > (PosW+1)'(cap)) begin
          res_d.status = StOverflow;
          error_seen_d = 1'b1;
        end else if (item_q.dist_code >= 5'd30) begin
          res_d.status = StBadDist;
          error_seen_d = 1'b1;
        end else if (CmpW'(dist_w) > CmpW'(write_pos_q)) begin
          res_d.status = StFar;
          error_seen_d = 1'b1;
        end else begin
          res_d.last = 1'b0;
          remain_d = len_w;
          dist_d = dist_w;
          fill_d = '0;
          match_d = 1'b1;
          state_d = SRead;
        end
      end
      SRead: begin
        state_d = SWrite;
      end
      SWrite: begin
        mem_we = 1'b1;
        write_pos_d = write_pos_q + PosW'(1);
        res_d.bytes[fill_q[LaneW-1:0]] = rdata_q;
        res_d.count = 4'(fill_q) + 4'd1;
        remain_d = remain_q - LenW'(1);
        fill_d = fill_q + (LaneW+1)'(1);
        if (remain_q == LenW'(1)) begin
          res_d.last = 1'b1;
          state_d = SEmit;
        end else if (fill_q == (LaneW+1)'(NLanes - 1)) begin
          state_d = SEmit;
        end else begin
          state_d = SRead;
        end
      end
      SEmit: begin
        if (out_o.ready) begin
          if (match_q && !res_q.last) begin
            res_d = '0;
            fill_d = '0;
            state_d = SRead;
          end else begin
            state_d = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      write_pos_q <= '0;
      error_seen_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      state_q <= state_d;
      write_pos_q <= write_pos_d;
      error_seen_q <= error_seen_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remain_q <= remain_d;
    dist_q <= dist_d;
    fill_q <= fill_d;
    res_q <= res_d;
  end

  `DLZ_ASSERT_NEXT(a_err_sticky, error_seen_q, error_seen_q, "error flag cleared")
  `DLZ_ASSERT_IMP(a_pos_cap, 1'b1, write_pos_q <= DepthP, "write position past store")
  `DLZ_ASSERT_IMP(a_count_max, out_o.valid, res_q.count <= 4'(NLanes), "too many lanes")
  `DLZ_ASSERT_NEXT(a_pos_step, state_q != SWrite && state_q != SDec,
                   write_pos_q == $past(write_pos_q), "write position moved")
endmodule
